// ===== src/pl3p_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_pkg
// Shared widths and payload types for the plane-from-three-points pipeline.
// ----------------------------------------------------------------------------
package pl3p_pkg;

   localparam int COORD_WIDTH      = 24;
   localparam int NORMAL_FRAC_BITS = 15;

   // Edge vectors, cross product and its magnitude.
   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int CROSS_W = 2 * EDGE_W;
   localparam int MAG_W   = 2 * COORD_WIDTH + 1;
   localparam int LZ_W    = $clog2(MAG_W);

   // Normalized components land in [2^30, 2^31) for the largest one.
   localparam int T_W     = 31;
   localparam int SQ_W    = 2 * T_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;

   // Per-lane division of t * 2^NF + len/2 by len.
   localparam int NUM_W   = T_W + NORMAL_FRAC_BITS + 1;
   localparam int Q_W     = NORMAL_FRAC_BITS + 1;
   localparam int DREM_W  = ROOT_W + 1;

   // Normal components, dot product and offset.
   localparam int NV_W    = NORMAL_FRAC_BITS + 1;
   localparam int PROD_W  = NV_W + COORD_WIDTH;
   localparam int DOT_W   = PROD_W + 2;
   localparam int NEG_W   = DOT_W - NORMAL_FRAC_BITS + 1;
   localparam int OFS_W   = COORD_WIDTH + 1;

   // Stream payload widths, rounded up to whole bytes.
   localparam int IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((3 * NV_W + OFS_W + 7) / 8) * 8;

   // One point; index 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][COORD_WIDTH-1:0] point_type;

   typedef struct packed {
      logic [2:0]          neg;
      logic [2:0][T_W-1:0] t;
      point_type           p0;
      logic                degen;
   } norm_side_type;

   typedef struct packed {
      logic [2:0] neg;
      point_type  p0;
      logic       degen;
   } div_side_type;

endpackage
`default_nettype wire

// ===== src/pl3p_cross.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_cross
// Edge vectors and their exact cross product, three register stages.
// ----------------------------------------------------------------------------
module pl3p_cross import pl3p_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  point_type                 pa,
   input  point_type                 pb,
   input  point_type                 pc,
   output logic                      out_valid,
   output point_type                 out_p0,
   output logic signed [CROSS_W-1:0] out_c [3]
);

   localparam int A_IDX [3] = '{1, 2, 0};
   localparam int B_IDX [3] = '{2, 0, 1};

   logic [2:0]                v_ff;
   point_type                 p0_ff [3];
   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [EDGE_W-1:0]  e1_in [3];
   logic signed [EDGE_W-1:0]  e2_in [3];
   logic signed [CROSS_W-1:0] pr_ff [6];
   logic signed [CROSS_W-1:0] pr_in [6];
   logic signed [CROSS_W-1:0] c_ff  [3];
   logic signed [CROSS_W-1:0] c_in  [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e1_in[j] = $signed({pb[j][COORD_WIDTH-1], pb[j]})
                  - $signed({pa[j][COORD_WIDTH-1], pa[j]});
         e2_in[j] = $signed({pc[j][COORD_WIDTH-1], pc[j]})
                  - $signed({pa[j][COORD_WIDTH-1], pa[j]});
      end
      for (int i = 0; i < 3; i++) begin
         pr_in[2*i]   = e1_ff[A_IDX[i]] * e2_ff[B_IDX[i]];
         pr_in[2*i+1] = e1_ff[B_IDX[i]] * e2_ff[A_IDX[i]];
         c_in[i]      = pr_ff[2*i] - pr_ff[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         pr_ff    <= pr_in;
         c_ff     <= c_in;
         p0_ff[0] <= pa;
         p0_ff[1] <= p0_ff[0];
         p0_ff[2] <= p0_ff[1];
      end
   end

   assign out_valid = v_ff[2];
   assign out_p0    = p0_ff[2];
   assign out_c     = c_ff;

endmodule
`default_nettype wire

// ===== src/pl3p_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_norm
// Scales the cross product so its largest magnitude fills 31 bits, then
// forms the sum of squares. Five register stages.
// ----------------------------------------------------------------------------
module pl3p_norm import pl3p_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  point_type                 in_p0,
   input  logic signed [CROSS_W-1:0] in_c [3],
   output logic                      out_valid,
   output norm_side_type             out_side,
   output logic [SUM_W-1:0]          out_sum
);

   logic [4:0]          v_ff;
   point_type           p0_ff  [5];
   logic [2:0]          neg_ff [5];
   logic [3:0]          dg_ff;
   logic [MAG_W-1:0]    mag_ff  [3];
   logic [MAG_W-1:0]    mag_in  [3];
   logic [MAG_W-1:0]    mag5_ff [3];
   logic [MAG_W-1:0]    orv;
   logic [LZ_W-1:0]     lz_in;
   logic [LZ_W-1:0]     lz_ff;
   logic [MAG_W-1:0]    shifted [3];
   logic [2:0][T_W-1:0] t6_ff;
   logic [2:0][T_W-1:0] t6_in;
   logic [2:0][T_W-1:0] t7_ff;
   logic [2:0][T_W-1:0] t8_ff;
   logic [SQ_W-1:0]     sq_ff [3];
   logic [SQ_W-1:0]     sq_in [3];
   logic [SUM_W-1:0]    sum_ff;
   logic [2:0]          neg_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_c[i][CROSS_W-1];
         mag_in[i] = neg_in[i] ? MAG_W'(-in_c[i]) : MAG_W'(in_c[i]);
      end
      orv   = mag_ff[0] | mag_ff[1] | mag_ff[2];
      // Leading-zero count of the largest magnitude.
      lz_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (orv[b]) begin
            lz_in = LZ_W'(MAG_W - 1 - b);
         end
      end
      // A left shift that puts the top bit at the word's top keeps the
      // truncation of a plain right shift for large values.
      for (int i = 0; i < 3; i++) begin
         shifted[i] = mag5_ff[i] << lz_ff;
         t6_in[i]   = shifted[i][MAG_W-1 -: T_W];
         sq_in[i]   = t6_ff[i] * t6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         mag5_ff   <= mag_ff;
         lz_ff     <= lz_in;
         t6_ff     <= t6_in;
         t7_ff     <= t6_ff;
         t8_ff     <= t7_ff;
         sq_ff     <= sq_in;
         sum_ff    <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         dg_ff     <= {dg_ff[2:0], orv == '0};
         p0_ff[0]  <= in_p0;
         neg_ff[0] <= neg_in;
         for (int k = 1; k < 5; k++) begin
            p0_ff[k]  <= p0_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign out_valid      = v_ff[4];
   assign out_sum        = sum_ff;
   assign out_side.neg   = neg_ff[4];
   assign out_side.t     = t8_ff;
   assign out_side.p0    = p0_ff[4];
   assign out_side.degen = dg_ff[3];

endmodule
`default_nettype wire

// ===== src/pl3p_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module pl3p_sqrt import pl3p_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  norm_side_type     in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output norm_side_type     out_side
);

   logic [ROOT_W-1:0] v_ff;
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SUM_W-1:0]  x_ff     [ROOT_W];
   norm_side_type     side_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_src  [ROOT_W];
   logic [ROOT_W-1:0] root_src [ROOT_W];
   logic [SUM_W-1:0]  x_src    [ROOT_W];
   logic [REM_W-1:0]  r2       [ROOT_W];
   logic [REM_W-1:0]  trial    [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   logic [SUM_W-1:0]  x_in     [ROOT_W];

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      x_src[0]    = in_sum;
      for (int k = 1; k < ROOT_W; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         x_src[k]    = x_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         // Bring down the next two radicand bits and try 4*root+1.
         r2[k]    = {rem_src[k][REM_W-3:0], x_src[k][SUM_W-1 -: 2]};
         trial[k] = {root_src[k], 2'b01};
         x_in[k]  = x_src[k] << 2;
         if (r2[k] >= trial[k]) begin
            rem_in[k]  = r2[k] - trial[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = r2[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff     <= rem_in;
         root_ff    <= root_in;
         x_ff       <= x_in;
         side_ff[0] <= in_side;
         for (int k = 1; k < ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ===== src/pl3p_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_div
// Three restoring dividers side by side: rounded t * 2^NF / len, one
// quotient bit per register stage after a setup stage.
// ----------------------------------------------------------------------------
module pl3p_div import pl3p_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_len,
   input  norm_side_type     in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_q [3],
   output div_side_type      out_side
);

   logic [Q_W:0]      v_ff;
   logic [DREM_W-1:0] rem_ff [Q_W+1][3];
   logic [Q_W-1:0]    low_ff [Q_W+1][3];
   logic [Q_W-1:0]    q_ff   [Q_W+1][3];
   logic [ROOT_W-1:0] len_ff [Q_W+1];
   div_side_type      side_ff [Q_W+1];
   logic [NUM_W-1:0]  num    [3];
   logic [DREM_W-1:0] r2     [1:Q_W][3];
   logic [DREM_W-1:0] rem_in [1:Q_W][3];
   logic [Q_W-1:0]    q_in   [1:Q_W][3];
   div_side_type      side_in;

   always_comb begin
      side_in = '{neg: in_side.neg, p0: in_side.p0, degen: in_side.degen};
      for (int i = 0; i < 3; i++) begin
         num[i] = (NUM_W'(in_side.t[i]) << NORMAL_FRAC_BITS) + NUM_W'(in_len >> 1);
      end
      for (int k = 1; k <= Q_W; k++) begin
         for (int i = 0; i < 3; i++) begin
            r2[k][i] = {rem_ff[k-1][i][DREM_W-2:0], low_ff[k-1][i][Q_W-1]};
            if (r2[k][i] >= {1'b0, len_ff[k-1]}) begin
               rem_in[k][i] = r2[k][i] - {1'b0, len_ff[k-1]};
               q_in[k][i]   = {q_ff[k-1][i][Q_W-2:0], 1'b1};
            end else begin
               rem_in[k][i] = r2[k][i];
               q_in[k][i]   = {q_ff[k-1][i][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Q_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // The quotient fits Q_W bits, so the top part starts below len.
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= DREM_W'(num[i] >> Q_W);
            low_ff[0][i] <= num[i][Q_W-1:0];
            q_ff[0][i]   <= '0;
         end
         len_ff[0]  <= in_len;
         side_ff[0] <= side_in;
         for (int k = 1; k <= Q_W; k++) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= rem_in[k][i];
               low_ff[k][i] <= low_ff[k-1][i] << 1;
               q_ff[k][i]   <= q_in[k][i];
            end
            len_ff[k]  <= len_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_q     = q_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule
`default_nettype wire

// ===== src/pl3p_offset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_offset
// Signs and clamps the normal, then forms d = -(n . p0) with rounding and
// saturation. Four register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module pl3p_offset import pl3p_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [Q_W-1:0]         in_q [3],
   input  div_side_type           in_side,
   output logic                   out_valid,
   output logic [2:0][NV_W-1:0]   out_normal,
   output logic [OFS_W-1:0]       out_offset,
   output logic                   out_degen
);

   localparam logic [Q_W-1:0]          Q_LIM   = Q_W'(1) << NORMAL_FRAC_BITS;
   localparam logic [Q_W-1:0]          Q_POS   = Q_LIM - Q_W'(1);
   localparam logic signed [DOT_W-1:0] RND     = DOT_W'(1) <<< (NORMAL_FRAC_BITS - 1);
   localparam logic signed [NEG_W-1:0] D_HI    = (NEG_W'(1) <<< COORD_WIDTH) - NEG_W'(1);
   localparam logic signed [NEG_W-1:0] D_LO    = -(NEG_W'(1) <<< COORD_WIDTH);
   localparam logic [OFS_W-1:0]        OFS_MAX = {1'b0, {COORD_WIDTH{1'b1}}};
   localparam logic [OFS_W-1:0]        OFS_MIN = {1'b1, {COORD_WIDTH{1'b0}}};

   logic [3:0]                v_ff;
   logic [3:0]                dg_ff;
   logic [2:0][NV_W-1:0]      nv_ff [4];
   logic [2:0][NV_W-1:0]      nv_in;
   point_type                 p0_ff;
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [DOT_W-1:0]   s_ff;
   logic signed [DOT_W-1:0]   s_in;
   logic signed [NEG_W-1:0]   fl;
   logic signed [NEG_W-1:0]   nd;
   logic [OFS_W-1:0]          d_in;
   logic [OFS_W-1:0]          d_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // A degenerate item gets a zero normal, which also zeroes d.
         if (in_side.degen) begin
            nv_in[i] = '0;
         end else if (in_side.neg[i]) begin
            nv_in[i] = (in_q[i] > Q_LIM) ? Q_LIM : NV_W'(-in_q[i]);
         end else begin
            nv_in[i] = (in_q[i] > Q_POS) ? Q_POS : in_q[i];
         end
         prod_in[i] = $signed(nv_ff[0][i]) * $signed(p0_ff[i]);
      end
      s_in = DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1]) + DOT_W'(prod_ff[2]) + RND;
      fl   = NEG_W'(s_ff >>> NORMAL_FRAC_BITS);
      nd   = -fl;
      if (nd > D_HI) begin
         d_in = OFS_MAX;
      end else if (nd < D_LO) begin
         d_in = OFS_MIN;
      end else begin
         d_in = OFS_W'(nd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nv_ff[0] <= nv_in;
         nv_ff[1] <= nv_ff[0];
         nv_ff[2] <= nv_ff[1];
         nv_ff[3] <= nv_ff[2];
         dg_ff    <= {dg_ff[2:0], in_side.degen};
         p0_ff    <= in_side.p0;
         prod_ff  <= prod_in;
         s_ff     <= s_in;
         d_ff     <= d_in;
      end
   end

   assign out_valid  = v_ff[3];
   assign out_normal = nv_ff[3];
   assign out_offset = d_ff;
   assign out_degen  = dg_ff[3];

endmodule
`default_nettype wire

// ===== src/plane_from_three_points_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plane_from_three_points_core
// Plane through three points: unit normal from the cross product of the
// edges and offset d = -(n . p0), flagged when the points are collinear.
// ----------------------------------------------------------------------------
//   channel   direction  tdata (low bit first)                          tuser
//   req_      in         p0.x p0.y p0.z p1.x p1.y p1.z p2.x p2.y p2.z    -
//   rsp_      out        normal_x normal_y normal_z plane_offset         degenerate
//
// One item enters per clock unless rsp stalls; the longest parts of the path
// from req to rsp are the 32 stages of the square root and 17 stages of the dividers.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline advances when the rsp register is empty or taken, so
// a stall on rsp freezes every stage and no item is lost or repeated.
// ----------------------------------------------------------------------------
module plane_from_three_points_core import pl3p_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // third_x, third_y, third_z
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // normal_x, normal_y, normal_z, plane_offset, zero fill
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]            rsp_tuser
);

   logic                      adv;
   point_type                 pa;
   point_type                 pb;
   point_type                 pc;
   logic                      cr_valid;
   point_type                 cr_p0;
   logic signed [CROSS_W-1:0] cr_c [3];
   logic                      nm_valid;
   norm_side_type             nm_side;
   logic [SUM_W-1:0]          nm_sum;
   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   norm_side_type             sq_side;
   logic                      dv_valid;
   logic [Q_W-1:0]            dv_q [3];
   div_side_type              dv_side;
   logic [2:0][NV_W-1:0]      normal;
   logic [OFS_W-1:0]          offset;
   logic                      degen;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign pa = req_tdata[3*COORD_WIDTH-1:0];
   assign pb = req_tdata[6*COORD_WIDTH-1:3*COORD_WIDTH];
   assign pc = req_tdata[9*COORD_WIDTH-1:6*COORD_WIDTH];

   pl3p_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .pa        (pa),
      .pb        (pb),
      .pc        (pc),
      .out_valid (cr_valid),
      .out_p0    (cr_p0),
      .out_c     (cr_c)
   );

   pl3p_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (cr_valid),
      .in_p0     (cr_p0),
      .in_c      (cr_c),
      .out_valid (nm_valid),
      .out_side  (nm_side),
      .out_sum   (nm_sum)
   );

   pl3p_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (nm_valid),
      .in_sum    (nm_sum),
      .in_side   (nm_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   pl3p_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_len    (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   pl3p_offset u_offset (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (dv_valid),
      .in_q       (dv_q),
      .in_side    (dv_side),
      .out_valid  (rsp_tvalid),
      .out_normal (normal),
      .out_offset (offset),
      .out_degen  (degen)
   );

   assign rsp_tdata = OUT_DATA_W'({offset, normal});
   assign rsp_tuser = degen;

endmodule
`default_nettype wire

// ===== src/pl3p_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pl3p_checker
// Port-level checks on the plane-from-three-points core.
// ----------------------------------------------------------------------------
module pl3p_checker import pl3p_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [IN_DATA_W-1:0]  req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   // A held result keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // The input side is held back exactly when a result waits untaken.
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow the output stall");

   // Collinear points give all-zero coefficients.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate item with nonzero coefficients");

   // A proper plane always has a nonzero normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[3*NV_W-1:0] != '0)
      else $error("zero normal on a non-degenerate item");

   // Nothing comes out right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind plane_from_three_points_core pl3p_checker u_checker (.*);
`default_nettype wire

// ===== sim/plane_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_checker
// Watches both streams of the plane core, predicts the normal, offset and
// collinear flag of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module plane_checker import pl3p_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]            rsp_tuser,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic signed [NV_W-1:0]  nrm [3];
      logic signed [OFS_W-1:0] ofs;
      logic                    degen;
   } plane_type;

   plane_type planes_due [$];

   function automatic bit [63:0] root_floor(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic plane_type plane_of(logic [IN_DATA_W-1:0] data);
      plane_type res;
      longint p [3][3];
      longint e1 [3], e2 [3], c [3], nv [3];
      bit [63:0] mag [3], t [3], sumsq, len, m, lim;
      int top, bl, sh;
      longint s, d, dmax;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            p[i][j] = longint'($signed(data[(i*3+j)*COORD_WIDTH +: COORD_WIDTH]));
      for (int j = 0; j < 3; j++) begin
         e1[j] = p[1][j] - p[0][j];
         e2[j] = p[2][j] - p[0][j];
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      top = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (c[i] < 0) ? -c[i] : c[i];
         bl = 0;
         for (int k = 0; k < 64; k++) if (mag[i][k]) bl = k + 1;
         if (bl > top) top = bl;
      end
      for (int i = 0; i < 3; i++) res.nrm[i] = '0;
      res.ofs = '0;
      res.degen = 1'b1;
      if (top == 0) return res;
      // The largest magnitude is brought into [2^30, 2^31).
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         if (top > 31) begin
            sh = top - 31;
            t[i] = mag[i] >> sh;
         end else begin
            sh = 31 - top;
            t[i] = mag[i] << sh;
         end
         sumsq = sumsq + t[i] * t[i];
      end
      len = root_floor(sumsq);
      lim = 64'd1 << NORMAL_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         m = ((t[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
         if (c[i] < 0) begin
            if (m > lim) m = lim;
            nv[i] = -longint'(m);
         end else begin
            if (m > lim - 1) m = lim - 1;
            nv[i] = longint'(m);
         end
         res.nrm[i] = nv[i][NV_W-1:0];
      end
      s = nv[0] * p[0][0] + nv[1] * p[0][1] + nv[2] * p[0][2];
      d = -((s + (longint'(1) << (NORMAL_FRAC_BITS - 1))) >>> NORMAL_FRAC_BITS);
      dmax = longint'(1) << COORD_WIDTH;
      if (d > dmax - 1) d = dmax - 1;
      if (d < -dmax) d = -dmax;
      res.ofs = d[OFS_W-1:0];
      res.degen = 1'b0;
      return res;
   endfunction

   assign pending = planes_due.size();

   always @(posedge clock) begin
      plane_type want, got;
      bit bad;
      if (!reset) begin
         if (req_tvalid && req_tready)
            planes_due.insert(planes_due.size(), plane_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 3; i++) got.nrm[i] = rsp_tdata[i*NV_W +: NV_W];
            got.ofs = rsp_tdata[3*NV_W +: OFS_W];
            got.degen = rsp_tuser[0];
            if (planes_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected item: n=(%0d %0d %0d) d=%0d degen=%0d",
                           got.nrm[0], got.nrm[1], got.nrm[2], got.ofs, got.degen);
            end else begin
               want = planes_due.pop_front();
               bad = (want.degen !== got.degen) || (want.ofs !== got.ofs);
               for (int i = 0; i < 3; i++) if (want.nrm[i] !== got.nrm[i]) bad = 1;
               if (bad) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected n=(%0d %0d %0d) d=%0d degen=%0d,",
                              want.nrm[0], want.nrm[1], want.nrm[2], want.ofs,
                              want.degen,
                              " got n=(%0d %0d %0d) d=%0d degen=%0d",
                              got.nrm[0], got.nrm[1], got.nrm[2], got.ofs, got.degen);
               end
            end
         end
      end
   end

endmodule

// ===== sim/plane_from_three_points_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_from_three_points_core_tb
// Drives point triples into the plane core with random gaps and back
// pressure: directed corners, collinear and coincident sets, then random
// triples, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module plane_from_three_points_core_tb;
   import pl3p_pkg::*;

   localparam int LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   int                    fail_count, pending, cycles = 0;
   bit                    calm = 0;

   plane_from_three_points_core i_dut (.*);

   plane_checker i_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Sink side: a fresh random stall, which may be zero, ahead of every item.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_points(input logic [COORD_WIDTH-1:0] pt [9]);
      int gap;
      @(negedge clock);
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_tdata[i*COORD_WIDTH +: COORD_WIDTH] <= pt[i];
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [COORD_WIDTH-1:0] rand_coord(int span);
      logic signed [31:0] v;
      if (span >= COORD_WIDTH) v = $urandom;
      else v = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
      return v[COORD_WIDTH-1:0];
   endfunction

   initial begin
      logic [COORD_WIDTH-1:0] pt [9];
      logic signed [COORD_WIDTH-1:0] mx, mn;
      logic signed [COORD_WIDTH-1:0] dir [3];
      int kind, span, k;
      mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all zero, coincident, collinear, axis planes, corners.
      for (int i = 0; i < 9; i++) pt[i] = '0;
      send_points(pt);
      for (int i = 0; i < 9; i++) pt[i] = mx;
      send_points(pt);
      for (int i = 0; i < 9; i++) pt[i] = mn;
      send_points(pt);
      for (int i = 0; i < 9; i++) pt[i] = COORD_WIDTH'((i / 3) * 256);
      send_points(pt);
      for (int i = 0; i < 9; i++) pt[i] = (i % 3 == 0) ? mn : mx;
      send_points(pt);
      pt = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
      send_points(pt);
      pt = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
      send_points(pt);
      pt = '{mx, mx, mx, 256, 0, 0, 0, 256, 0};
      send_points(pt);
      pt = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
      send_points(pt);
      pt = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
      send_points(pt);
      pt = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
      send_points(pt);
      pt = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};
      send_points(pt);
      pt = '{0, 0, mx, 1, 0, mx, 0, 1, mx};
      send_points(pt);
      pt = '{mn, 0, 0, mn, 1, 0, mn, 0, 1};
      send_points(pt);
      pt = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
      send_points(pt);
      pt = '{0, 0, 0, 0, 0, 0, 5, 7, 9};
      send_points(pt);
      pt = '{mx, mn, 0, mn, mx, 0, 0, 0, mx};
      send_points(pt);

      for (int n = 0; n < 900; n++) begin
         calm = (n % 200) >= 150;
         kind = $urandom_range(0, 9);
         span = $urandom_range(2, COORD_WIDTH);
         if (kind <= 5) begin
            for (int i = 0; i < 9; i++) pt[i] = rand_coord(span);
         end else if (kind <= 7) begin
            // Collinear: second and third lie on a line through the first.
            for (int i = 0; i < 3; i++) begin
               pt[i] = rand_coord(span);
               dir[i] = rand_coord(($urandom_range(0, 1) == 1) ? 6 : 12);
            end
            k = $urandom_range(0, 8) - 4;
            for (int i = 0; i < 3; i++) begin
               pt[3+i] = pt[i] + dir[i];
               pt[6+i] = COORD_WIDTH'(pt[i] + dir[i] * k);
            end
         end else if (kind == 8) begin
            for (int i = 0; i < 3; i++) pt[i] = rand_coord(span);
            for (int i = 3; i < 9; i++) pt[i] = pt[i%3] + rand_coord(3);
         end else begin
            for (int i = 0; i < 9; i++)
               pt[i] = ($urandom_range(0, 1) == 1) ? mx : mn;
         end
         send_points(pt);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pl3p_pkg.sv
src/pl3p_cross.sv
src/pl3p_norm.sv
src/pl3p_sqrt.sv
src/pl3p_div.sv
src/pl3p_offset.sv
src/plane_from_three_points_core.sv
src/pl3p_checker.sv
sim/plane_checker.sv
sim/plane_from_three_points_core_tb.sv
